@@ rtl/adler32_line_parity_locator_top_macros.svh @@
// Assertion macros for the line parity locator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ADLER32_LINE_PARITY_LOCATOR_TOP_MACROS_SVH
`define ADLER32_LINE_PARITY_LOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define A32LPL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("a32lpl assertion failed");
`define A32LPL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("a32lpl assertion failed");
`else
`define A32LPL_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define A32LPL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/a32lpl_pkg.sv @@
// Shared types, operation codes and helper functions for the line parity locator.
// No dependencies.
`timescale 1ns / 1ps
package a32lpl_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int CHECK_BITS = 32;
  localparam int REPORT_WORDS = 16;
  localparam int REP_IDX_W = $clog2(REPORT_WORDS);
  localparam int OUT_W = 16;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  typedef logic [1:0] op_t;
  localparam op_t OP_BYTE = 2'd0;
  localparam op_t OP_EOL = 2'd1;
  localparam op_t OP_REPORT = 2'd2;

  typedef struct packed {
    logic byte_en;
    logic restart;
  } adl_ctrl_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Report word k covers checksum bits 0-7 for k < 8 and bits 16-23 otherwise.
  function automatic logic [4:0] print_bit(input logic [REP_IDX_W-1:0] k);
    return {k[3], 1'b0, k[2:0]};
  endfunction

endpackage

@@ rtl/a32lpl_if.sv @@
// Request and result channel interfaces for the line parity locator.
// Depends on a32lpl_pkg.
`timescale 1ns / 1ps
interface a32lpl_in_if
  import a32lpl_pkg::*;
  ();
  logic valid;
  logic ready;
  op_t operation;
  logic [7:0] data_byte;
  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface a32lpl_out_if
  import a32lpl_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [15:0] line_total;
  logic [4:0] bit_index;
  logic [15:0] parity_word;
  logic overflowed;
  logic last;
  modport source (output valid, output line_total, output bit_index, output parity_word,
                  output overflowed, output last, input ready);
  modport sink (input valid, input line_total, input bit_index, input parity_word,
                input overflowed, input last, output ready);
endinterface

@@ rtl/a32lpl_adler.sv @@
// Per-line Adler-32 accumulator with conditional-subtraction reduction.
// Depends on a32lpl_pkg.
`timescale 1ns / 1ps
module a32lpl_adler
  import a32lpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  adl_ctrl_t   ctrl,
  input  logic [7:0]  data_byte,
  output logic [31:0] check
);

  logic [15:0] sum_low_r, sum_low_nxt;
  logic [15:0] sum_high_r, sum_high_nxt;
  logic [16:0] low_add, high_add;
  logic [15:0] low_red;

  always_comb begin
    low_add = {1'b0, sum_low_r} + {9'd0, data_byte};
    low_red = (low_add >= ADLER_MOD) ? 16'(low_add - ADLER_MOD) : low_add[15:0];
    high_add = {1'b0, sum_high_r} + {1'b0, low_red};
    sum_low_nxt = sum_low_r;
    sum_high_nxt = sum_high_r;
    if (ctrl.restart) begin
      sum_low_nxt = 16'd1;
      sum_high_nxt = 16'd0;
    end else if (ctrl.byte_en && !is_blank(data_byte)) begin
      sum_low_nxt = low_red;
      sum_high_nxt = (high_add >= ADLER_MOD) ? 16'(high_add - ADLER_MOD) : high_add[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_low_r <= 16'd1;
      sum_high_r <= 16'd0;
    end else begin
      sum_low_r <= sum_low_nxt;
      sum_high_r <= sum_high_nxt;
    end
  end

  assign check = {sum_high_r, sum_low_r};

endmodule

@@ rtl/adler32_line_parity_locator_top.sv @@
// Byte and end-of-line requests produce no result.
// A report request loads a 16-word result buffer; its first word is offered in the
// next cycle and the words leave one per cycle while the result side is ready.
// Throughput is one request per cycle, except that a report that follows another
// waits until that one's last word leaves, which a stall on the result side delays.
// Synchronous active-low reset sets the sums to 1 and 0 and clears line count, flag and parity words at once.
`timescale 1ns / 1ps
`include "adler32_line_parity_locator_top_macros.svh"
module adler32_line_parity_locator_top
  import a32lpl_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  a32lpl_in_if.sink    in_req,
  a32lpl_out_if.source out_rsp
);

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  logic in_fire, out_fire, out_last_fire;
  logic is_eol, is_rep, line_full;
  adl_ctrl_t adl_ctrl;
  logic [31:0] check, value;

  logic [LINE_BITS-1:0] line_cnt_r, line_cnt_nxt;
  logic sat_r, sat_nxt;
  logic [LINE_BITS-1:0] parity_r [CHECK_BITS];
  logic [LINE_BITS-1:0] parity_nxt [CHECK_BITS];

  logic rep_busy_r;
  logic [REP_IDX_W-1:0] rep_idx_r;
  logic [OUT_W-1:0] rep_word_r [REPORT_WORDS];
  logic [OUT_W-1:0] rep_total_r;
  logic rep_ovf_r;

  logic [OUT_W-1:0] line16;
  logic [OUT_W-1:0] word16 [REPORT_WORDS];

  assign out_fire = out_rsp.valid && out_rsp.ready;
  assign out_last_fire = out_fire && out_rsp.last;
  assign in_req.ready = !rep_busy_r || (in_req.operation != OP_REPORT) || out_last_fire;
  assign in_fire = in_req.valid && in_req.ready;
  assign is_eol = in_fire && (in_req.operation == OP_EOL);
  assign is_rep = in_fire && (in_req.operation == OP_REPORT);
  assign line_full = (line_cnt_r == LINE_MAX);

  assign adl_ctrl.byte_en = in_fire && (in_req.operation == OP_BYTE);
  assign adl_ctrl.restart = is_eol;

  a32lpl_adler u_adler (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (adl_ctrl),
    .data_byte (in_req.data_byte),
    .check     (check)
  );

  assign value = check - 32'd1;

  always_comb begin
    line_cnt_nxt = line_cnt_r;
    sat_nxt = sat_r;
    parity_nxt = parity_r;
    if (is_eol) begin
      if (line_full) begin
        sat_nxt = 1'b1;
      end else begin
        line_cnt_nxt = line_cnt_r + LINE_BITS'(1);
        for (int i = 0; i < CHECK_BITS; i++) begin
          if (value[i]) begin
            parity_nxt[i] = parity_r[i] ^ line_cnt_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      sat_r <= 1'b0;
      for (int i = 0; i < CHECK_BITS; i++) begin
        parity_r[i] <= '0;
      end
    end else begin
      line_cnt_r <= line_cnt_nxt;
      sat_r <= sat_nxt;
      parity_r <= parity_nxt;
    end
  end

  // The result fields are 16 bits wide; the line width may be narrower or wider.
  if (LINE_BITS >= OUT_W) begin : g_trunc
    assign line16 = line_cnt_r[OUT_W-1:0];
    for (genvar k = 0; k < REPORT_WORDS; k++) begin : g_word
      assign word16[k] = parity_r[print_bit(REP_IDX_W'(k))][OUT_W-1:0];
    end
  end else begin : g_ext
    assign line16 = {{(OUT_W-LINE_BITS){1'b0}}, line_cnt_r};
    for (genvar k = 0; k < REPORT_WORDS; k++) begin : g_word
      assign word16[k] = {{(OUT_W-LINE_BITS){1'b0}}, parity_r[print_bit(REP_IDX_W'(k))]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_busy_r <= 1'b0;
      rep_idx_r <= '0;
    end else if (is_rep) begin
      rep_busy_r <= 1'b1;
      rep_idx_r <= '0;
    end else if (out_fire) begin
      rep_idx_r <= rep_idx_r + REP_IDX_W'(1);
      if (out_rsp.last) begin
        rep_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_rep) begin
      rep_word_r <= word16;
      rep_total_r <= line16;
      rep_ovf_r <= sat_r;
    end else if (out_fire) begin
      for (int k = 0; k < REPORT_WORDS - 1; k++) begin
        rep_word_r[k] <= rep_word_r[k+1];
      end
    end
  end

  assign out_rsp.valid = rep_busy_r;
  assign out_rsp.line_total = rep_total_r;
  assign out_rsp.bit_index = print_bit(rep_idx_r);
  assign out_rsp.parity_word = rep_word_r[0];
  assign out_rsp.overflowed = rep_ovf_r;
  assign out_rsp.last = (rep_idx_r == REP_IDX_W'(REPORT_WORDS - 1));

  `A32LPL_ASSERT_IMPL(a_rep_no_overlap, clk, rst_n, is_rep, !rep_busy_r || out_last_fire)
  `A32LPL_ASSERT_NEXT(a_rep_starts, clk, rst_n, is_rep, rep_busy_r && rep_idx_r == '0)
  `A32LPL_ASSERT_NEXT(a_sat_sticky, clk, rst_n, sat_r, sat_r)
  `A32LPL_ASSERT_NEXT(a_line_step, clk, rst_n, is_eol && !line_full,
                      line_cnt_r == $past(line_cnt_r) + LINE_BITS'(1))
  `A32LPL_ASSERT_NEXT(a_full_holds, clk, rst_n, is_eol && line_full,
                      line_cnt_r == LINE_MAX && sat_r)

endmodule

@@ tb/sv/adler32_line_parity_locator_top_tb.sv @@
// Self-checking testbench for adler32_line_parity_locator_top: directed and random
// request streams, checked word by word against an internal predictor.
// Depends on a32lpl_pkg, a32lpl_if and the adler32_line_parity_locator_top RTL.
`timescale 1ns / 1ps
module adler32_line_parity_locator_top_tb;
  import a32lpl_pkg::*;

  localparam int LINE_W = LINE_BITS_DEF;
  localparam longint unsigned LINE_MAX = (64'd1 << LINE_W) - 64'd1;
  localparam int unsigned MODULUS = 65521;
  localparam op_t OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 160;
  localparam int DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    op_t        op;
    logic [7:0] data;
    bit         quiet;
  } locator_req_t;

  typedef struct {
    logic [15:0] line_total;
    logic [4:0]  bit_index;
    logic [15:0] parity_word;
    logic        overflowed;
    logic        last;
  } report_word_t;

  logic clk;
  logic rst_n;

  a32lpl_in_if  in_req ();
  a32lpl_out_if out_rsp ();

  adler32_line_parity_locator_top #(
    .LINE_BITS(LINE_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  locator_req_t    req_queue[$];
  report_word_t    words_due[$];
  int unsigned     run_low;
  int unsigned     run_high;
  longint unsigned lines_done;
  logic            count_full;
  longint unsigned parity_words[32];
  longint          cycle_count;
  int              failures;
  int              send_gap;
  int              recv_gap;
  bit              req_taken;
  bit              calm;
  logic [7:0]      blank_chars[6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void advance_locator(op_t op, logic [7:0] b);
    logic [31:0] checksum;
    int          k;
    case (op)
      OP_BYTE: begin
        if (!(b inside {8'h20, [8'h09:8'h0D]})) begin
          run_low += b;
          if (run_low >= MODULUS) run_low -= MODULUS;
          run_high += run_low;
          if (run_high >= MODULUS) run_high -= MODULUS;
        end
      end
      OP_EOL: begin
        checksum = {run_high[15:0], run_low[15:0]} - 32'd1;
        run_low = 1;
        run_high = 0;
        if (lines_done >= LINE_MAX) begin
          count_full = 1'b1;
        end else begin
          lines_done++;
          for (int i = 0; i < 32; i++) begin
            if (checksum[i]) parity_words[i] = (parity_words[i] ^ lines_done) & LINE_MAX;
          end
        end
      end
      OP_REPORT: begin
        k = 0;
        for (int i = 0; i < 32; i++) begin
          if ((i % 16) < 8) begin
            words_due.push_back('{line_total: 16'(lines_done), bit_index: 5'(i),
                                  parity_word: 16'(parity_words[i]), overflowed: count_full,
                                  last: (k == REPORT_WORDS - 1)});
            k++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic queue_req(op_t op, logic [7:0] data, bit quiet = 1'b0);
    req_queue.push_back('{op: op, data: data, quiet: quiet});
  endtask

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 3) == 0) return blank_chars[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) cycle_count++;

  always @(posedge clk) begin : watch_channels
    report_word_t want;
    req_taken = 1'b0;
    if (rst_n) begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (words_due.size() == 0) begin
          $error("parity word arrived with none expected");
          failures++;
        end else begin
          want = words_due.pop_front();
          check_field("line_total", want.line_total, out_rsp.line_total);
          check_field("bit_index", want.bit_index, out_rsp.bit_index);
          check_field("parity_word", want.parity_word, out_rsp.parity_word);
          check_field("overflowed", want.overflowed, out_rsp.overflowed);
          check_field("last", want.last, out_rsp.last);
        end
      end
      if (in_req.valid && in_req.ready) begin
        req_taken = 1'b1;
        advance_locator(in_req.operation, in_req.data_byte);
      end
    end
  end

  always @(negedge clk) begin : drive_requests
    locator_req_t nxt;
    if (rst_n && (!in_req.valid || req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_req.valid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        nxt = req_queue.pop_front();
        in_req.valid <= 1'b1;
        in_req.operation <= nxt.op;
        in_req.data_byte <= nxt.data;
        if (nxt.quiet) calm = 1'b1;
        else if ($urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 9);
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 9);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("adler32_line_parity_locator_top: mismatch");
    $finish;
  end

  initial begin
    int         made;
    int         len;
    int         pick;
    logic [7:0] b;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.operation = OP_BYTE;
    in_req.data_byte = 8'h00;
    out_rsp.ready = 1'b0;
    run_low = 1;
    run_high = 0;
    lines_done = 0;
    count_full = 1'b0;
    foreach (parity_words[i]) parity_words[i] = 0;
    cycle_count = 0;
    failures = 0;
    send_gap = 0;
    recv_gap = 0;
    req_taken = 1'b0;
    calm = 1'b0;

    // Directed: empty report, byte extremes, every whitespace code and its neighbors,
    // an empty line, the unused code and ignored data on control requests.
    queue_req(OP_REPORT, 8'hFF);
    queue_req(OP_BYTE, 8'h00);
    queue_req(OP_BYTE, 8'hFF);
    foreach (blank_chars[i]) queue_req(OP_BYTE, blank_chars[i]);
    queue_req(OP_BYTE, 8'h08);
    queue_req(OP_BYTE, 8'h0E);
    queue_req(OP_BYTE, 8'h1F);
    queue_req(OP_BYTE, 8'h21);
    queue_req(OP_EOL, 8'hFF);
    queue_req(OP_EOL, 8'h00);
    queue_req(OP_UNUSED, 8'hA5);
    queue_req(OP_BYTE, 8'h41);
    queue_req(OP_EOL, 8'h5A);
    queue_req(OP_REPORT, 8'h00);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(0, 10);
        repeat (len) queue_req(OP_BYTE, text_byte());
        queue_req(OP_EOL, 8'($urandom_range(0, 255)));
        made += len + 1;
      end else if (pick < 92) begin
        queue_req(OP_REPORT, 8'($urandom_range(0, 255)));
        made++;
      end else if (pick < 96) begin
        queue_req(OP_UNUSED, 8'($urandom_range(0, 255)));
        made++;
      end else begin
        // A run of high bytes drives the high sum past the modulus.
        len = $urandom_range(24, 40);
        repeat (len) begin
          b = ($urandom_range(0, 7) == 0) ? text_byte() : 8'hFF;
          queue_req(OP_BYTE, b);
        end
        queue_req(OP_EOL, 8'($urandom_range(0, 255)));
        queue_req(OP_REPORT, 8'($urandom_range(0, 255)));
        made += len + 2;
      end
    end
    queue_req(OP_REPORT, 8'h00);

    // Finish without idling on either side: short lines with reports close behind.
    repeat (3) begin
      repeat (4) queue_req(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
      queue_req(OP_EOL, 8'($urandom_range(0, 255)), 1'b1);
      queue_req(OP_REPORT, 8'($urandom_range(0, 255)), 1'b1);
    end
    queue_req(OP_REPORT, 8'h00, 1'b1);
    queue_req(OP_BYTE, 8'h7E, 1'b1);
    queue_req(OP_EOL, 8'h00, 1'b1);
    queue_req(OP_UNUSED, 8'h3C, 1'b1);
    queue_req(OP_REPORT, 8'hFF, 1'b1);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    while (req_queue.size() != 0 || in_req.valid) @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("adler32_line_parity_locator_top: match");
    end else begin
      $display("adler32_line_parity_locator_top: mismatch");
    end
    $finish;
  end

endmodule
